FILE: sv/rgb_to_c1c2c3_angles_macros.svh
// Assertion macros for the c1c2c3 angle converter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RGB_TO_C1C2C3_ANGLES_MACROS_SVH
`define RGB_TO_C1C2C3_ANGLES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C1C2C3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define C1C2C3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/c1c2c3_pkg.sv
// Shared types and constants for the c1c2c3 angle converter.
// Holds the CORDIC arctangent table and the lane result format; no dependencies.
package c1c2c3_pkg;

  // Fixed-point layout of the CORDIC datapath.
  localparam int unsigned GUARD_BITS = 24;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned ZW         = 32;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned LANES      = 3;

  // pi/2 in Q2.30.
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // floor(atan(2^-i) * 2^30) for each iteration.
  localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
    32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
    32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
    32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
    32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
  };

  // Operand conditions that bypass the CORDIC result.
  typedef struct packed {
    logic den_zero;
    logic num_zero;
  } lane_flags_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic signed [ZW-1:0] z;
    lane_flags_t          flags;
  } lane_res_t;

endpackage

FILE: sv/c1c2c3_pix_if.sv
// Pixel input channel: valid/ready handshake with blue, green and red samples.
// Standalone; the sample width is a parameter of the interface.
interface c1c2c3_pix_if #(
  parameter int unsigned SAMPLE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] blue;
  logic [SAMPLE_BITS-1:0] green;
  logic [SAMPLE_BITS-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

FILE: sv/c1c2c3_ang_if.sv
// Angle output channel: valid/ready handshake with the three c1c2c3 angles.
// Uses c1c2c3_pkg for the angle width.
interface c1c2c3_ang_if;
  import c1c2c3_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] c1;
  logic [ANGLE_W-1:0] c2;
  logic [ANGLE_W-1:0] c3;

  modport source (output valid, c1, c2, c3, input ready);
  modport sink   (input valid, c1, c2, c3, output ready);
endinterface

FILE: sv/rgb_to_c1c2c3_angles.sv
// The converter takes one pixel per clock and returns its three c1c2c3 angles
// (c1 from red, c2 from green, c3 from blue) as unsigned radians with
// ANGLE_FRAC_BITS fraction bits, at a sustained rate of one pixel per cycle while
// the output is taken; a stalled output holds the flow once the pipeline is full.
// Three CORDIC lanes run side by side, one per angle, each with an entry stage
// and min(CORDIC_STAGES, 24) iteration stages, and a merge stage rounds and
// registers the result. Stages that hold no pixel let the next one move up, so
// input transfers continue while a result waits at the output until the pipeline
// is full.
`include "rgb_to_c1c2c3_angles_macros.svh"

module rgb_to_c1c2c3_angles #(
  parameter int unsigned SAMPLE_BITS     = 8,
  parameter int unsigned ANGLE_FRAC_BITS = 15,
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  c1c2c3_pix_if.sink      pix_i,
  c1c2c3_ang_if.source    ang_o
);
  import c1c2c3_pkg::*;

  localparam int unsigned NSTAGES =
    (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned DEPTH = NSTAGES + 2;

  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] valid_d;
  logic [DEPTH-1:0] adv;
  lane_res_t        lane_res [LANES];
  logic             in_xfer;
  logic             out_xfer;

  // A stage may load when it or any stage after it is empty, or the output drains.
  always_comb begin
    for (int k = 0; k < int'(DEPTH); k++) begin
      adv[k] = ang_o.ready || (((~valid_q) & ({DEPTH{1'b1}} << k)) != '0);
    end
  end

  // Valid bits move forward with the stages they describe.
  always_comb begin
    valid_d[0] = adv[0] ? pix_i.valid : valid_q[0];
    for (int k = 1; k < int'(DEPTH); k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pix_i.ready = adv[0];
  assign ang_o.valid = valid_q[DEPTH-1];
  assign in_xfer     = pix_i.valid && pix_i.ready;
  assign out_xfer    = ang_o.valid && ang_o.ready;

  // Lane for c1: red over max(green, blue).
  c1c2c3_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STAGES      (NSTAGES)
  ) u_lane_c1 (
    .clk_i   (clk_i),
    .en_i    (adv[NSTAGES:0]),
    .num_i   (pix_i.red),
    .oth_a_i (pix_i.green),
    .oth_b_i (pix_i.blue),
    .res_o   (lane_res[0])
  );

  // Lane for c2: green over max(red, blue).
  c1c2c3_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STAGES      (NSTAGES)
  ) u_lane_c2 (
    .clk_i   (clk_i),
    .en_i    (adv[NSTAGES:0]),
    .num_i   (pix_i.green),
    .oth_a_i (pix_i.red),
    .oth_b_i (pix_i.blue),
    .res_o   (lane_res[1])
  );

  // Lane for c3: blue over max(green, red).
  c1c2c3_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STAGES      (NSTAGES)
  ) u_lane_c3 (
    .clk_i   (clk_i),
    .en_i    (adv[NSTAGES:0]),
    .num_i   (pix_i.blue),
    .oth_a_i (pix_i.green),
    .oth_b_i (pix_i.red),
    .res_o   (lane_res[2])
  );

  // Rounding and the output register.
  c1c2c3_merge #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_merge (
    .clk_i (clk_i),
    .en_i  (adv[DEPTH-1]),
    .res_i (lane_res),
    .c1_o  (ang_o.c1),
    .c2_o  (ang_o.c2),
    .c3_o  (ang_o.c3)
  );

  // Without a draining output, the input is only ready when some stage has room.
  `C1C2C3_ASSERT_IMP(a_ready_needs_room, pix_i.ready && !ang_o.ready, !(&valid_q), "ready with a full pipeline")

  // An empty output register never blocks the input.
  `C1C2C3_ASSERT_IMP(a_empty_out_ready, !valid_q[DEPTH-1], pix_i.ready, "stalled with empty output")

  // Pixels in flight change only by transfers on the two channels.
  `C1C2C3_ASSERT_NXT(a_occupancy, 1'b1, $countones(valid_q) == $past($countones(valid_q)) + int'($past(in_xfer)) - int'($past(out_xfer)), "pixel lost or duplicated")

endmodule

FILE: sv/c1c2c3_lane.sv
// One CORDIC lane: picks the larger denominator, then runs a pipelined
// vectoring-mode CORDIC, one iteration per stage. Depends on c1c2c3_pkg.
module c1c2c3_lane #(
  parameter int unsigned SAMPLE_BITS = 8,
  parameter int unsigned STAGES      = 16
) (
  input  logic                   clk_i,
  input  logic [STAGES:0]        en_i,
  input  logic [SAMPLE_BITS-1:0] num_i,
  input  logic [SAMPLE_BITS-1:0] oth_a_i,
  input  logic [SAMPLE_BITS-1:0] oth_b_i,
  output c1c2c3_pkg::lane_res_t  res_o
);
  import c1c2c3_pkg::*;

  // Headroom for the CORDIC gain and the vector length, plus a sign bit.
  localparam int unsigned XW = SAMPLE_BITS + GUARD_BITS + 3;

  logic [SAMPLE_BITS-1:0] den;
  logic signed [XW-1:0]   x_q     [STAGES+1];
  logic signed [XW-1:0]   y_q     [STAGES+1];
  logic signed [ZW-1:0]   z_q     [STAGES+1];
  lane_flags_t            flags_q [STAGES+1];

  // Denominator is the larger of the two other channels.
  assign den = (oth_a_i > oth_b_i) ? oth_a_i : oth_b_i;

  // Entry stage loads the scaled operands; each later stage is one iteration.
  // A stage loads whenever its enable is set, bubbles included.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]                <= {3'b000, den, {GUARD_BITS{1'b0}}};
      y_q[0]                <= {3'b000, num_i, {GUARD_BITS{1'b0}}};
      z_q[0]                <= '0;
      flags_q[0].den_zero   <= (den == '0);
      flags_q[0].num_zero   <= (num_i == '0);
    end
    for (int k = 1; k <= int'(STAGES); k++) begin
      if (en_i[k]) begin
        flags_q[k] <= flags_q[k-1];
        if (!y_q[k-1][XW-1]) begin
          x_q[k] <= x_q[k-1] + (y_q[k-1] >>> (k-1));
          y_q[k] <= y_q[k-1] - (x_q[k-1] >>> (k-1));
          z_q[k] <= z_q[k-1] + ATAN_Q30[k-1];
        end else begin
          x_q[k] <= x_q[k-1] - (y_q[k-1] >>> (k-1));
          y_q[k] <= y_q[k-1] + (x_q[k-1] >>> (k-1));
          z_q[k] <= z_q[k-1] - ATAN_Q30[k-1];
        end
      end
    end
  end

  // The final x magnitude is not needed; only the accumulated angle leaves.
  assign res_o.z     = z_q[STAGES];
  assign res_o.flags = flags_q[STAGES];

endmodule

FILE: sv/c1c2c3_merge.sv
// Merge stage: applies the zero-denominator rules, clamps and rounds each
// lane's angle, and registers the three angles as one result. Uses c1c2c3_pkg.
module c1c2c3_merge #(
  parameter int unsigned ANGLE_FRAC_BITS = 15
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  c1c2c3_pkg::lane_res_t     res_i [c1c2c3_pkg::LANES],
  output logic [c1c2c3_pkg::ANGLE_W-1:0] c1_o,
  output logic [c1c2c3_pkg::ANGLE_W-1:0] c2_o,
  output logic [c1c2c3_pkg::ANGLE_W-1:0] c3_o
);
  import c1c2c3_pkg::*;

  localparam int unsigned SH       = 30 - ANGLE_FRAC_BITS;
  localparam logic [31:0] HALF_LSB = 32'd1 << (SH - 1);

  logic [30:0]        zc      [LANES];
  logic [31:0]        rounded [LANES];
  logic [ANGLE_W-1:0] angle   [LANES];
  logic [ANGLE_W-1:0] angle_q [LANES];

  // Clamp to [0, pi/2], then round half up to the output fraction.
  always_comb begin
    for (int l = 0; l < int'(LANES); l++) begin
      if (res_i[l].flags.den_zero) begin
        zc[l] = res_i[l].flags.num_zero ? '0 : HALF_PI_Q30;
      end else if (res_i[l].z[ZW-1]) begin
        zc[l] = '0;
      end else if (res_i[l].z[30:0] > HALF_PI_Q30) begin
        zc[l] = HALF_PI_Q30;
      end else begin
        zc[l] = res_i[l].z[30:0];
      end
      rounded[l] = {1'b0, zc[l]} + HALF_LSB;
      angle[l]   = ANGLE_W'(rounded[l] >> SH);
    end
  end

  // Output register; it holds while the downstream side stalls.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle;
    end
  end

  assign c1_o = angle_q[0];
  assign c2_o = angle_q[1];
  assign c3_o = angle_q[2];

endmodule

FILE: verif/rgb_to_c1c2c3_angles_tb.sv
// Self-checking testbench for the c1c2c3 angle converter rgb_to_c1c2c3_angles.
// Depends on c1c2c3_pkg, the c1c2c3_pix_if and c1c2c3_ang_if interfaces, and the RTL.
// A bit-exact CORDIC predictor checks every output transfer under random flow control.
`timescale 1ns / 100ps

module rgb_to_c1c2c3_angles_tb;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned ANGLE_W     = c1c2c3_pkg::ANGLE_W;
  localparam int unsigned ITERATIONS  = 16;
  localparam int unsigned RANDOM_PIX  = 1600;
  localparam int unsigned PHASE_LEN   = 100;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned STALL_LIMIT = 5000;

  // pi/2 in Q2.30 and the CORDIC rotation angles floor(atan(2^-i) * 2^30).
  localparam longint RIGHT_ANGLE_Q30 = 64'sd1686629713;
  localparam longint ROT_STEP_Q30 [ITERATIONS] = '{
    64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
    64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
    64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
    64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF
  };

  // Flow-control phases: which side inserts idle cycles.
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_TAKE_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    pace_t               pace;
  } pixel_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] c1;
    logic [ANGLE_W-1:0] c2;
    logic [ANGLE_W-1:0] c3;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  c1c2c3_pix_if #(.SAMPLE_BITS(SAMPLE_W)) pix_ch ();
  c1c2c3_ang_if                          ang_ch ();

  rgb_to_c1c2c3_angles uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_ch),
    .ang_o (ang_ch)
  );

  pixel_t  pixels_to_send[$];
  angles_t angles_due[$];
  int      queued_count = 0;
  int      fault_count  = 0;
  int      quiet_cycles = 0;
  bit      pix_taken    = 1'b0;
  pace_t   cur_pace     = PACE_FREE;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp a Q2.30 angle to [0, pi/2] and round half up to Q1.15.
  function automatic logic [ANGLE_W-1:0] round_to_q15(input longint z);
    longint t;
    t = z;
    if (t < 0) t = 0;
    if (t > RIGHT_ANGLE_Q30) t = RIGHT_ANGLE_Q30;
    t = (t + (64'sd1 <<< 14)) >>> 15;
    return t[ANGLE_W-1:0];
  endfunction

  // First-quadrant atan2(num, den) by vectoring CORDIC with floor shifts.
  function automatic logic [ANGLE_W-1:0] cordic_angle(input logic [SAMPLE_W-1:0] num,
                                                      input logic [SAMPLE_W-1:0] den);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    int     i;
    if (den == '0) return (num == '0) ? '0 : round_to_q15(RIGHT_ANGLE_Q30);
    x = longint'(den) <<< 24;
    y = longint'(num) <<< 24;
    z = 0;
    for (i = 0; i < ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ROT_STEP_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ROT_STEP_Q30[i];
      end
    end
    return round_to_q15(z);
  endfunction

  // Each angle takes one channel over the larger of the other two.
  function automatic angles_t pixel_angles(input logic [SAMPLE_W-1:0] b,
                                           input logic [SAMPLE_W-1:0] g,
                                           input logic [SAMPLE_W-1:0] r);
    angles_t a;
    a.c1 = cordic_angle(r, (g > b) ? g : b);
    a.c2 = cordic_angle(g, (r > b) ? r : b);
    a.c3 = cordic_angle(b, (g > r) ? g : r);
    return a;
  endfunction

  task automatic queue_pixel(input int b, input int g, input int r);
    pixel_t p;
    p.blue  = b[SAMPLE_W-1:0];
    p.green = g[SAMPLE_W-1:0];
    p.red   = r[SAMPLE_W-1:0];
    p.pace  = pace_t'((queued_count / PHASE_LEN) % 4);
    pixels_to_send.push_back(p);
    queued_count++;
  endtask

  // Driver: updates the pixel channel and the result ready at the falling edge.
  always @(negedge clk_i) begin : drive_pixels
    pixel_t head;
    bit     send;
    int     send_gap;
    int     take_stall;
    if (rst_ni) begin
      if (pix_taken) begin
        void'(pixels_to_send.pop_front());
        pix_taken = 1'b0;
        send = 1'b0;
      end else begin
        // A pixel that is offered stays offered until its transfer.
        send = pix_ch.valid;
      end
      head = pixels_to_send.size() > 0 ? pixels_to_send[0] : '0;
      if (pixels_to_send.size() > 0) cur_pace = head.pace;
      send_gap   = (cur_pace == PACE_SEND_GAPS)   ? 45 : (cur_pace == PACE_BOTH) ? 32 : 0;
      take_stall = (cur_pace == PACE_TAKE_STALLS) ? 45 : (cur_pace == PACE_BOTH) ? 32 : 0;
      if (!send && pixels_to_send.size() > 0)
        send = ($urandom_range(99) >= send_gap);
      pix_ch.valid <= send;
      if (send) begin
        pix_ch.blue  <= head.blue;
        pix_ch.green <= head.green;
        pix_ch.red   <= head.red;
      end else begin
        pix_ch.blue  <= SAMPLE_W'($urandom);
        pix_ch.green <= SAMPLE_W'($urandom);
        pix_ch.red   <= SAMPLE_W'($urandom);
      end
      ang_ch.ready <= ($urandom_range(99) >= take_stall);
    end
  end

  // Monitor: predicts on each pixel transfer and checks each result transfer.
  always @(posedge clk_i) begin : check_angles
    angles_t got;
    angles_t want;
    if (rst_ni) begin
      if (pix_ch.valid && pix_ch.ready) begin
        angles_due.push_back(pixel_angles(pix_ch.blue, pix_ch.green, pix_ch.red));
        pix_taken = 1'b1;
      end
      if (ang_ch.valid && ang_ch.ready) begin
        got.c1 = ang_ch.c1;
        got.c2 = ang_ch.c2;
        got.c3 = ang_ch.c3;
        if (angles_due.size() == 0) begin
          $error("result with no pixel outstanding: c1=%0d c2=%0d c3=%0d",
                 got.c1, got.c2, got.c3);
          fault_count++;
        end else begin
          want = angles_due.pop_front();
          if (got.c1 !== want.c1) begin
            $error("c1 mismatch: expected %0d, got %0d", want.c1, got.c1);
            fault_count++;
          end
          if (got.c2 !== want.c2) begin
            $error("c2 mismatch: expected %0d, got %0d", want.c2, got.c2);
            fault_count++;
          end
          if (got.c3 !== want.c3) begin
            $error("c3 mismatch: expected %0d, got %0d", want.c3, got.c3);
            fault_count++;
          end
        end
      end
      // Watchdog on cycles without any transfer.
      if ((pix_ch.valid && pix_ch.ready) || (ang_ch.valid && ang_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int sel;
    int b;
    int g;
    int r;
    int base;
    rst_ni       = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.blue  = '0;
    pix_ch.green = '0;
    pix_ch.red   = '0;
    ang_ch.ready = 1'b0;

    // Directed pixels: all zero, full scale, lone channels, ties and alternating bits.
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 1, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(255, 255, 0);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 255);
    queue_pixel(1, 255, 255);
    queue_pixel(255, 1, 1);
    queue_pixel(1, 1, 1);
    queue_pixel(128, 64, 32);
    queue_pixel(85, 170, 85);
    queue_pixel(170, 85, 170);
    queue_pixel(254, 255, 253);
    queue_pixel(1, 2, 3);
    queue_pixel(255, 128, 0);

    // Random pixels, biased toward zeros, small values and near ties.
    for (n = 0; n < RANDOM_PIX; n++) begin
      sel = $urandom_range(99);
      b = $urandom_range(255);
      g = $urandom_range(255);
      r = $urandom_range(255);
      if (sel < 15) begin
        b = $urandom_range(3);
        g = $urandom_range(3);
        r = $urandom_range(3);
      end else if (sel < 30) begin
        if ($urandom_range(1)) b = 0;
        if ($urandom_range(1)) g = 0;
        if ($urandom_range(1)) r = 0;
      end else if (sel < 45) begin
        case ($urandom_range(2))
          0:       g = b;
          1:       r = g;
          default: b = r;
        endcase
      end else if (sel < 60) begin
        base = $urandom_range(250);
        b = base + $urandom_range(5);
        g = base + $urandom_range(5);
        r = base + $urandom_range(5);
      end
      queue_pixel(b, g, r);
    end

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pixels_to_send.size() == 0 && angles_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/c1c2c3_pkg.sv
sv/c1c2c3_pix_if.sv
sv/c1c2c3_ang_if.sv
sv/c1c2c3_lane.sv
sv/c1c2c3_merge.sv
sv/rgb_to_c1c2c3_angles.sv
verif/rgb_to_c1c2c3_angles_tb.sv
